// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the clique search RTL.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("clique search check failed");
`define CHK_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("clique search forbidden condition");
`else
`define CHK_ASSERT(lbl, clk, rst_n, prop)
`define CHK_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== rtl/mcs_pkg.sv =====
// Shared sizes, codes and controller/datapath interface structs for the
// monochromatic clique search block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mcs_pkg;

  localparam int MaxVertices = 64;
  localparam int MaxClique   = 8;
  localparam int Cells       = MaxVertices * MaxVertices;
  localparam int AddrW       = $clog2(Cells);
  localparam int PosW        = AddrW + 1;
  localparam int VtxW        = $clog2(MaxVertices);
  localparam int NW          = VtxW + 1;
  localparam int KIdxW       = $clog2(MaxClique);
  localparam int KW          = KIdxW + 1;
  localparam int CountW      = 33;
  localparam int VcW         = 7;
  localparam int CsW         = 4;
  localparam int CfgDataW    = 7;
  localparam int CfgAddrW    = 1;
  localparam int OpW         = 2;
  localparam int InDataW     = 8;
  localparam int StatW       = 2;
  localparam int OutBits     = 1 + MaxClique * VtxW + CountW;
  localparam int OutDataW    = ((OutBits + 7) / 8) * 8;

  localparam logic [CfgAddrW-1:0] REG_VERTEX_COUNT = 1'b0;
  localparam logic [CfgAddrW-1:0] REG_CLIQUE_SIZE  = 1'b1;

  typedef enum logic [OpW-1:0] {
    OP_LOAD       = 2'd0,
    OP_NEW_MATRIX = 2'd1,
    OP_RESTART    = 2'd2,
    OP_FIND       = 2'd3
  } op_t;

  typedef enum logic [StatW-1:0] {
    STAT_FOUND      = 2'd0,
    STAT_EXHAUSTED  = 2'd1,
    STAT_NOT_LOADED = 2'd2
  } status_t;

  typedef struct packed {
    logic    load;
    logic    new_matrix;
    logic    restart;
    logic    start_walk;
    logic    seed;
    logic    calc_addr;
    logic    read_bit;
    logic    compare;
    logic    advance;
    logic    adv_last;
    logic    emit_found;
    logic    emit_code;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic loaded;
    logic walk_done;
    logic mismatch;
    logic last_pair;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/mcs_datapath.sv =====
// Datapath: config registers, edge bit memory, subset registers, pair
// walker, running count and output word register. Uses mcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcs_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [mcs_pkg::CfgAddrW-1:0]   cfg_addr,
  input  wire logic [mcs_pkg::CfgDataW-1:0]   cfg_wdata,
  input  wire logic                           in_edge,
  input  wire mcs_pkg::dp_cmd_t               cmd,
  output mcs_pkg::dp_sts_t                    sts,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [mcs_pkg::StatW-1:0]           out_tuser,
  output logic [mcs_pkg::OutDataW-1:0]        out_tdata
);

  localparam int AW = mcs_pkg::VtxW + mcs_pkg::NW + 1;

  logic [mcs_pkg::VcW-1:0]    vcount_r;
  logic [mcs_pkg::CsW-1:0]    csize_r;
  logic [mcs_pkg::PosW-1:0]   load_pos_r;
  logic [mcs_pkg::VtxW-1:0]   sub_r   [mcs_pkg::MaxClique];
  logic [mcs_pkg::VtxW-1:0]   sub_adv [mcs_pkg::MaxClique];
  logic                       walk_done_r;
  logic [mcs_pkg::CountW-1:0] count_r;
  logic [mcs_pkg::KIdxW-1:0]  pi_r;
  logic [mcs_pkg::KIdxW-1:0]  pj_r;
  logic                       ref_phase_r;
  logic                       ref_r;
  logic [mcs_pkg::AddrW-1:0]  addr_r;
  logic                       bit_r;
  logic                       out_valid_r;
  logic [mcs_pkg::StatW-1:0]  out_user_r;
  logic [mcs_pkg::OutDataW-1:0] out_data_r;
  logic                       mem [mcs_pkg::Cells];

  logic [mcs_pkg::NW-1:0]     n;
  logic [mcs_pkg::KW-1:0]     k;
  logic [2*mcs_pkg::NW-1:0]   nn;
  logic                       load_ok;
  logic                       do_restart;
  logic [mcs_pkg::KIdxW-1:0]  row_idx;
  logic [mcs_pkg::KIdxW-1:0]  col_idx;
  logic [AW-1:0]              addr_full;
  logic [mcs_pkg::KIdxW-1:0]  adv_p;
  logic                       adv_hit;
  logic [mcs_pkg::KIdxW-1:0]  adv_pos;
  logic [mcs_pkg::VtxW-1:0]   adv_base;
  logic [mcs_pkg::NW:0]       limit;
  logic                       pair_wrap;
  logic [mcs_pkg::OutDataW-1:0] pack_found;

  assign n = (vcount_r > mcs_pkg::NW'(mcs_pkg::MaxVertices)) ?
             mcs_pkg::NW'(mcs_pkg::MaxVertices) : vcount_r;

  always_comb begin
    if (csize_r < mcs_pkg::CsW'(2)) begin
      k = mcs_pkg::KW'(2);
    end else if (csize_r > mcs_pkg::CsW'(mcs_pkg::MaxClique)) begin
      k = mcs_pkg::KW'(mcs_pkg::MaxClique);
    end else begin
      k = mcs_pkg::KW'(csize_r);
    end
  end

  assign nn         = (2*mcs_pkg::NW)'(n) * (2*mcs_pkg::NW)'(n);
  assign load_ok    = (2*mcs_pkg::NW)'(load_pos_r) < nn;
  assign do_restart = cfg_we | cmd.restart | cmd.new_matrix;

  assign row_idx   = ref_phase_r ? mcs_pkg::KIdxW'(0) : pi_r;
  assign col_idx   = ref_phase_r ? mcs_pkg::KIdxW'(1) : pj_r;
  assign addr_full = AW'(sub_r[row_idx]) * AW'(n) + AW'(sub_r[col_idx]);

  assign pair_wrap = (mcs_pkg::KW'(pi_r) + mcs_pkg::KW'(1)) == mcs_pkg::KW'(pj_r);

  assign sts.loaded    = (2*mcs_pkg::NW)'(load_pos_r) == nn;
  assign sts.walk_done = walk_done_r;
  assign sts.mismatch  = !ref_phase_r && (bit_r != ref_r);
  assign sts.last_pair = ref_phase_r ? (k == mcs_pkg::KW'(2)) :
                         (pair_wrap && ((mcs_pkg::KW'(pj_r) + mcs_pkg::KW'(1)) == k));
  assign sts.out_free  = !out_valid_r || out_tready;

  // successor subset: bump the highest movable index at or below adv_p
  assign adv_p = cmd.adv_last ? mcs_pkg::KIdxW'(k - mcs_pkg::KW'(1)) : pj_r;

  always_comb begin
    adv_hit = 1'b0;
    adv_pos = '0;
    limit   = '0;
    for (int x = 0; x < mcs_pkg::MaxClique; x++) begin
      limit = (mcs_pkg::NW+1)'(n) - (mcs_pkg::NW+1)'(k) + (mcs_pkg::NW+1)'(x);
      if ((mcs_pkg::KIdxW'(x) <= adv_p) &&
          ((mcs_pkg::NW+1)'(sub_r[x]) < limit)) begin
        adv_hit = 1'b1;
        adv_pos = mcs_pkg::KIdxW'(x);
      end
    end
  end

  assign adv_base = sub_r[adv_pos] + mcs_pkg::VtxW'(1);

  always_comb begin
    for (int x = 0; x < mcs_pkg::MaxClique; x++) begin
      if (mcs_pkg::KIdxW'(x) >= adv_pos) begin
        sub_adv[x] = adv_base + mcs_pkg::VtxW'(x) - mcs_pkg::VtxW'(adv_pos);
      end else begin
        sub_adv[x] = sub_r[x];
      end
    end
  end

  always_comb begin
    pack_found = '0;
    pack_found[0] = ref_r;
    for (int x = 0; x < mcs_pkg::MaxClique; x++) begin
      if (mcs_pkg::KW'(x) < k) begin
        pack_found[1 + x*mcs_pkg::VtxW +: mcs_pkg::VtxW] = sub_r[x];
      end
    end
    pack_found[1 + mcs_pkg::MaxClique*mcs_pkg::VtxW +: mcs_pkg::CountW] =
      count_r + mcs_pkg::CountW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= mcs_pkg::VcW'(42);
      csize_r     <= mcs_pkg::CsW'(5);
      load_pos_r  <= '0;
      walk_done_r <= 1'b0;
      count_r     <= '0;
      ref_phase_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int x = 0; x < mcs_pkg::MaxClique; x++) begin
        sub_r[x] <= mcs_pkg::VtxW'(x);
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          mcs_pkg::REG_VERTEX_COUNT: vcount_r <= cfg_wdata[mcs_pkg::VcW-1:0];
          mcs_pkg::REG_CLIQUE_SIZE:  csize_r  <= cfg_wdata[mcs_pkg::CsW-1:0];
        endcase
      end
      if (cmd.new_matrix) begin
        load_pos_r <= '0;
      end else if (cmd.load && load_ok) begin
        load_pos_r <= load_pos_r + mcs_pkg::PosW'(1);
      end
      if (do_restart) begin
        walk_done_r <= 1'b0;
        count_r     <= '0;
        for (int x = 0; x < mcs_pkg::MaxClique; x++) begin
          sub_r[x] <= mcs_pkg::VtxW'(x);
        end
      end else begin
        if (cmd.start_walk && (n < mcs_pkg::NW'(k))) begin
          walk_done_r <= 1'b1;
        end
        if (cmd.advance) begin
          if (adv_hit) begin
            sub_r <= sub_adv;
          end else begin
            walk_done_r <= 1'b1;
          end
        end
        if (cmd.emit_found) begin
          count_r <= count_r + mcs_pkg::CountW'(1);
        end
      end
      if (cmd.seed) begin
        ref_phase_r <= 1'b1;
      end else if (cmd.compare) begin
        ref_phase_r <= 1'b0;
      end
      if (cmd.emit_found || cmd.emit_code) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed) begin
      pi_r <= '0;
      pj_r <= mcs_pkg::KIdxW'(2);
    end else if (cmd.compare && !ref_phase_r && !sts.mismatch && !sts.last_pair) begin
      if (pair_wrap) begin
        pi_r <= '0;
        pj_r <= pj_r + mcs_pkg::KIdxW'(1);
      end else begin
        pi_r <= pi_r + mcs_pkg::KIdxW'(1);
      end
    end
    if (cmd.compare && ref_phase_r) begin
      ref_r <= bit_r;
    end
    if (cmd.calc_addr) begin
      addr_r <= addr_full[mcs_pkg::AddrW-1:0];
    end
    if (cmd.emit_found) begin
      out_user_r <= mcs_pkg::STAT_FOUND;
      out_data_r <= pack_found;
    end else if (cmd.emit_code) begin
      out_user_r <= cmd.code;
      out_data_r <= mcs_pkg::OutDataW'({count_r,
                                        {(1 + mcs_pkg::MaxClique*mcs_pkg::VtxW){1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      mem[load_pos_r[mcs_pkg::AddrW-1:0]] <= in_edge;
    end
    if (cmd.read_bit) begin
      bit_r <= mem[addr_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/mcs_ctrl.sv =====
// Controller: decodes input words and sequences the subset walk, pair
// reads and result emission. Uses mcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcs_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [mcs_pkg::OpW-1:0]   in_op,
  input  wire mcs_pkg::dp_sts_t          sts,
  output mcs_pkg::dp_cmd_t               cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_ADDR,
    S_READ,
    S_CMP,
    S_FOUND,
    S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  mcs_pkg::status_t  code_r, code_nxt;
  logic              in_tready_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    code_nxt  = code_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          unique case (mcs_pkg::op_t'(in_op))
            mcs_pkg::OP_LOAD:       cmd.load       = 1'b1;
            mcs_pkg::OP_NEW_MATRIX: cmd.new_matrix = 1'b1;
            mcs_pkg::OP_RESTART:    cmd.restart    = 1'b1;
            mcs_pkg::OP_FIND:       state_nxt      = S_START;
          endcase
        end
      end
      S_START: begin
        if (!sts.loaded) begin
          code_nxt  = mcs_pkg::STAT_NOT_LOADED;
          state_nxt = S_EMIT;
        end else begin
          cmd.start_walk = 1'b1;
          state_nxt      = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.walk_done) begin
          code_nxt  = mcs_pkg::STAT_EXHAUSTED;
          state_nxt = S_EMIT;
        end else begin
          cmd.seed  = 1'b1;
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.calc_addr = 1'b1;
        state_nxt     = S_READ;
      end
      S_READ: begin
        cmd.read_bit = 1'b1;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        priority if (sts.mismatch) begin
          cmd.advance = 1'b1;
          state_nxt   = S_WALK;
        end else if (sts.last_pair) begin
          state_nxt = S_FOUND;
        end else begin
          state_nxt = S_ADDR;
        end
      end
      S_FOUND: begin
        if (sts.out_free) begin
          cmd.emit_found = 1'b1;
          cmd.advance    = 1'b1;
          cmd.adv_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_code = 1'b1;
          cmd.code      = code_r;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      code_r      <= mcs_pkg::STAT_EXHAUSTED;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      in_tready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_tready = in_tready_r;

endmodule

`default_nettype wire

// ===== rtl/monochromatic_clique_search.sv =====
// Top level of the monochromatic clique search: joins controller and
// datapath. Uses mcs_pkg, mcs_ctrl, mcs_datapath and assert_macros.svh.
//
//   channel | direction | handshake         | word
//   in_     | slave     | tvalid/tready     | tuser: op; tdata: edge_bit
//   out_    | master    | tvalid/tready     | tuser: status; tdata: result
//   cfg_    | write     | cfg_we            | cfg_addr index, cfg_wdata value
//
// Load, new matrix and restart words are handled in the idle state.
// A find word checks that the matrix is loaded, then for each subset visited
// computes the address, reads the edge bit and compares for each pair (the
// reference pair included), then emits a result, or an exhaustion status when
// the walk runs out.
// Reset is synchronous; no clearing pass, the edge memory is filled by loads.
// Input words keep flowing while a result waits; a find that finishes
// holds in the controller until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module monochromatic_clique_search (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [mcs_pkg::OpW-1:0]         in_tuser,   // [1:0] op
  input  wire logic [mcs_pkg::InDataW-1:0]     in_tdata,   // [0] edge_bit, rest zero
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [mcs_pkg::StatW-1:0]            out_tuser,  // [1:0] status
  // [0] clique_color, [6:1] member_a, [12:7] member_b, [18:13] member_c,
  // [24:19] member_d, [30:25] member_e, [36:31] member_f, [42:37] member_g,
  // [48:43] member_h, [81:49] found_total, rest zero
  output logic [mcs_pkg::OutDataW-1:0]         out_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [mcs_pkg::CfgAddrW-1:0]    cfg_addr,
  input  wire logic [mcs_pkg::CfgDataW-1:0]    cfg_wdata
);

  mcs_pkg::dp_cmd_t dp_cmd;
  mcs_pkg::dp_sts_t dp_sts;

  mcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  mcs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_edge    (in_tdata[0]),
    .cmd        (dp_cmd),
    .sts        (dp_sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  `CHK_NEVER(a_emit_when_busy, clk, rst_n, (dp_cmd.emit_found || dp_cmd.emit_code) && !dp_sts.out_free)
  `CHK_NEVER(a_ready_while_walking, clk, rst_n, in_tready && (dp_cmd.compare || dp_cmd.seed || dp_cmd.advance))
  `CHK_ASSERT(a_found_status, clk, rst_n, dp_cmd.emit_found |=> (out_tvalid && out_tuser == mcs_pkg::STAT_FOUND))

endmodule

`default_nettype wire

// ===== tb/monochromatic_clique_search_tb.sv =====
// Self-checking testbench for monochromatic_clique_search: loads edge-color matrices,
// walks them with find words and checks every result word against a scoreboard.
// Depends on mcs_pkg and the monochromatic_clique_search RTL.
`timescale 1ns / 1ps

module monochromatic_clique_search_tb;
  import mcs_pkg::*;

  localparam int TotalLsb = 1 + MaxClique * VtxW;
  localparam int WordTarget = 850;
  localparam int SettleCycles = 20;
  localparam int BigN = 24;

  typedef struct packed {
    status_t                        status;
    logic                           color;
    logic [MaxClique-1:0][VtxW-1:0] member;
    logic [CountW-1:0]              total;
  } clique_word_t;

  class clique_scoreboard;
    bit                edge_color [Cells];
    int unsigned       fill_pos;
    int unsigned       pick [MaxClique];
    bit                walk_over;
    bit [CountW-1:0]   hits;
    bit [VcW-1:0]      vcount;
    bit [CsW-1:0]      csize;
    clique_word_t      pending [$];
    int                errors;

    function new();
      fill_pos = 0;
      vcount = 7'd42;
      csize = 4'd5;
      errors = 0;
      restart_walk();
    endfunction

    function void restart_walk();
      int i;
      for (i = 0; i < MaxClique; i++) pick[i] = i;
      walk_over = 0;
      hits = '0;
    endfunction

    function void set_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
      if (addr == REG_VERTEX_COUNT) vcount = data[VcW-1:0];
      else csize = data[CsW-1:0];
      restart_walk();
    endfunction

    function void step_walk(int p, int n, int k);
      int i, j;
      i = p + 1;
      while (i > 0) begin
        i--;
        if (pick[i] < n - k + i) begin
          pick[i]++;
          for (j = i + 1; j < k; j++) pick[j] = pick[j-1] + 1;
          return;
        end
      end
      walk_over = 1;
    endfunction

    function int first_mismatch(int n, int k, bit tone);
      int i, j;
      for (j = 2; j < k; j++)
        for (i = 0; i < j; i++)
          if (edge_color[pick[i] * n + pick[j]] != tone) return j;
      return k;
    endfunction

    function void note_word(op_t op, logic eb);
      int n, k, bad, j;
      bit tone, got;
      clique_word_t r;
      n = (vcount > MaxVertices) ? MaxVertices : vcount;
      k = (csize < 2) ? 2 : ((csize > MaxClique) ? MaxClique : csize);
      case (op)
        OP_LOAD: begin
          if (fill_pos < n * n) begin
            edge_color[fill_pos] = eb;
            fill_pos++;
          end
        end
        OP_NEW_MATRIX: begin
          fill_pos = 0;
          restart_walk();
        end
        OP_RESTART: restart_walk();
        default: begin
          r = '0;
          if (fill_pos != n * n) begin
            r.status = STAT_NOT_LOADED;
          end else begin
            if (n < k) walk_over = 1;
            r.status = STAT_EXHAUSTED;
            got = 0;
            while (!walk_over && !got) begin
              tone = edge_color[pick[0] * n + pick[1]];
              bad = first_mismatch(n, k, tone);
              if (bad == k) begin
                got = 1;
                r.status = STAT_FOUND;
                r.color = tone;
                for (j = 0; j < k; j++) r.member[j] = pick[j][VtxW-1:0];
                hits = hits + 1'b1;
                step_walk(k - 1, n, k);
              end else begin
                step_walk(bad, n, k);
              end
            end
          end
          r.total = hits;
          pending.push_back(r);
        end
      endcase
    endfunction

    function void check_result(logic [StatW-1:0] st, logic [OutDataW-1:0] data);
      clique_word_t want;
      int i;
      if (pending.size() == 0) begin
        $error("result word with no find waiting, status %0d", st);
        errors++;
      end else begin
        want = pending.pop_front();
        if (st !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, st);
          errors++;
        end
        if (data[0] !== want.color) begin
          $error("clique_color: expected %0d, got %0d", want.color, data[0]);
          errors++;
        end
        for (i = 0; i < MaxClique; i++)
          if (data[1 + i * VtxW +: VtxW] !== want.member[i]) begin
            $error("member_%c: expected %0d, got %0d", 97 + i, want.member[i],
                   data[1 + i * VtxW +: VtxW]);
            errors++;
          end
        if (data[TotalLsb +: CountW] !== want.total) begin
          $error("found_total: expected %0d, got %0d", want.total,
                 data[TotalLsb +: CountW]);
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [OpW-1:0]      in_tuser;
  logic [InDataW-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [StatW-1:0]    out_tuser;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;

  clique_scoreboard sb;
  bit               in_calm;
  bit               out_calm;
  int unsigned      cur_n;
  int unsigned      sent_count;

  monochromatic_clique_search dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("** monochromatic_clique_search: FAILED **");
    $finish;
  end

  // Send one word at a negedge; return at a negedge with tvalid still high.
  task automatic send_word(input op_t op, input logic eb);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {{(InDataW-1){1'b0}}, eb};
    do @(posedge clk); while (!in_tready);
    sb.note_word(op, eb);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic wait_idle();
    drain_results();
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = data;
    @(posedge clk);
    sb.set_reg(addr, data);
    @(negedge clk);
    cfg_we = 1'b0;
    @(negedge clk);
  endtask

  function automatic logic color_for(int style, logic tone);
    if (style == 0) return 1'($urandom_range(0, 1));
    if (style == 1) return ($urandom_range(0, 9) == 0) ? ~tone : tone;
    return tone;
  endfunction

  task automatic matrix_phase();
    int unsigned cells, short_by, finds, i, r, kv;
    int          style;
    logic        tone;
    logic [2:0]  junk;
    op_t         op;
    wait_idle();
    in_calm = ($urandom_range(0, 3) == 0);
    if (cur_n > 10 || $urandom_range(0, 2) != 0) begin
      r = $urandom_range(0, 19);
      if (r == 0) cur_n = $urandom_range(0, 2);
      else if (r < 17) cur_n = $urandom_range(3, 8);
      else cur_n = $urandom_range(9, 10);
      kv = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 6) : $urandom_range(0, 15);
      junk = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 1) != 0) begin
        write_reg(REG_VERTEX_COUNT, CfgDataW'(cur_n));
        write_reg(REG_CLIQUE_SIZE, {junk, kv[3:0]});
      end else begin
        write_reg(REG_CLIQUE_SIZE, {junk, kv[3:0]});
        write_reg(REG_VERTEX_COUNT, CfgDataW'(cur_n));
      end
    end
    cells = cur_n * cur_n;
    style = $urandom_range(0, 2);
    tone = 1'($urandom_range(0, 1));
    send_word(OP_NEW_MATRIX, 1'($urandom_range(0, 1)));
    short_by = (cells > 0 && $urandom_range(0, 9) == 0) ?
               $urandom_range(1, (cells < 3) ? cells : 3) : 0;
    for (i = 0; i < cells - short_by; i++) begin
      send_word(OP_LOAD, color_for(style, tone));
    end
    if (short_by > 0) begin
      send_word(OP_FIND, 1'($urandom_range(0, 1)));
      for (i = 0; i < short_by; i++) begin
        send_word(OP_LOAD, color_for(style, tone));
      end
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_word(OP_LOAD, 1'($urandom_range(0, 1)));
    finds = $urandom_range(2, 14);
    for (i = 0; i < finds; i++) begin
      r = $urandom_range(0, 19);
      if (r < 2) op = OP_RESTART;
      else if (r == 2) op = op_t'($urandom_range(0, 3));
      else op = OP_FIND;
      send_word(op, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 29) == 0) drain_results();
    end
  endtask

  // Result side: stall at random, check every accepted word.
  initial begin
    int unsigned gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) out_calm = ~out_calm;
      gap = out_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tuser, out_tdata);
      @(negedge clk);
    end
  end

  initial begin
    int unsigned i;
    logic [8:0] pattern;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    sent_count = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // find before any load, then too few vertices for an oversized clique
    send_word(OP_FIND, 1'b1);
    wait_idle();
    write_reg(REG_VERTEX_COUNT, 7'd3);
    write_reg(REG_CLIQUE_SIZE, 7'd15);
    send_word(OP_NEW_MATRIX, 1'b1);
    pattern = 9'b1_0110_1101;
    for (i = 0; i < 9; i++) send_word(OP_LOAD, pattern[i]);
    send_word(OP_FIND, 1'b0);
    send_word(OP_FIND, 1'b1);
    // clique size below range: every pair is a clique, then exhaustion
    wait_idle();
    write_reg(REG_CLIQUE_SIZE, 7'd0);
    repeat (4) send_word(OP_FIND, 1'b0);
    send_word(OP_LOAD, 1'b1);
    send_word(OP_FIND, 1'b0);
    send_word(OP_RESTART, 1'b1);
    send_word(OP_FIND, 1'b0);
    send_word(OP_NEW_MATRIX, 1'b0);
    send_word(OP_FIND, 1'b1);
    wait_idle();
    write_reg(REG_VERTEX_COUNT, 7'd127);
    send_word(OP_FIND, 1'b0);
    wait_idle();
    write_reg(REG_VERTEX_COUNT, 7'd0);
    send_word(OP_FIND, 1'b1);
    wait_idle();
    write_reg(REG_VERTEX_COUNT, 7'd1);
    send_word(OP_LOAD, 1'b0);
    send_word(OP_FIND, 1'b0);

    // larger matrix, mostly one color
    wait_idle();
    write_reg(REG_VERTEX_COUNT, CfgDataW'(BigN));
    write_reg(REG_CLIQUE_SIZE, 7'h72);
    send_word(OP_NEW_MATRIX, 1'b0);
    for (i = 0; i < BigN * BigN; i++)
      send_word(OP_LOAD, $urandom_range(0, 19) != 0);
    repeat (6) send_word(OP_FIND, 1'($urandom_range(0, 1)));
    wait_idle();
    write_reg(REG_CLIQUE_SIZE, 7'd8);
    repeat (6) send_word(OP_FIND, 1'($urandom_range(0, 1)));
    wait_idle();
    write_reg(REG_CLIQUE_SIZE, 7'd3);
    repeat (4) send_word(OP_FIND, 1'($urandom_range(0, 1)));
    cur_n = BigN;

    while (sent_count < WordTarget) matrix_phase();

    wait_idle();
    if (sb.errors == 0) begin
      $display("** monochromatic_clique_search: PASSED **");
    end else begin
      $display("** monochromatic_clique_search: FAILED **");
    end
    $finish;
  end

endmodule
